// File: sv/rap_pkg.sv
// ----------------------------------------------------------------------------
// Router advertisement parser package
// Shared types and constants for the byte-serial router advertisement parser.
// ----------------------------------------------------------------------------
package rap_pkg;

    // Message length handling
    localparam int LEN_W             = 12;
    localparam int MAX_MESSAGE_BYTES = 2048;
    localparam int OFF_W             = 11;
    localparam int HDR_BYTES         = 16;

    // ICMPv6 message types
    localparam logic [7:0] MSG_RS = 8'd133;
    localparam logic [7:0] MSG_RA = 8'd134;

    // Option types
    localparam logic [7:0] OPT_SRC_LLADDR = 8'd1;
    localparam logic [7:0] OPT_TGT_LLADDR = 8'd2;
    localparam logic [7:0] OPT_PREFIX     = 8'd3;
    localparam logic [7:0] OPT_REDIR_HDR  = 8'd4;
    localparam logic [7:0] OPT_MTU        = 8'd5;

    // Record kinds
    localparam logic [3:0] REC_HEADER   = 4'd0;
    localparam logic [3:0] REC_MTU      = 4'd1;
    localparam logic [3:0] REC_PREFIX   = 4'd2;
    localparam logic [3:0] REC_LLADDR   = 4'd3;
    localparam logic [3:0] REC_INVALID  = 4'd4;
    localparam logic [3:0] REC_UNKNOWN  = 4'd5;
    localparam logic [3:0] REC_TRAILING = 4'd6;
    localparam logic [3:0] REC_ZERO_LEN = 4'd7;
    localparam logic [3:0] REC_OVERLONG = 4'd8;
    localparam logic [3:0] REC_FILTER   = 4'd9;
    localparam logic [3:0] REC_TRUNC    = 4'd10;
    localparam logic [3:0] REC_END      = 4'd11;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_HDR,
        PH_OPT,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] packet_len;
    } t_in;

    typedef struct packed {
        logic [3:0]  rec_kind;
        logic [7:0]  small_value;
        logic        flag_a;
        logic        flag_b;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [7:0]  option_type;
        logic        valid_infinite;
        logic        preferred_infinite;
        logic        last;
    } t_rec;

    // Records produced by one byte, pushed into the output queue together
    typedef struct packed {
        logic [1:0] count;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

// File: sv/rap_core.sv
// ----------------------------------------------------------------------------
// Router advertisement parser core
// Holds the parse state and turns one byte into up to two records.
// ----------------------------------------------------------------------------
module rap_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  rap_pkg::t_in  i_item,
    output rap_pkg::t_push o_push
);

    logic [rap_pkg::LEN_W-1:0] r_pos, n_pos;
    rap_pkg::t_phase           r_phase, n_phase;
    logic [7:0]                r_opt_type, n_opt_type;
    logic [rap_pkg::OFF_W-1:0] r_opt_len, n_opt_len;
    logic [rap_pkg::OFF_W-1:0] r_off, n_off;
    logic [31:0]               r_acc_a, n_acc_a;
    logic [31:0]               r_acc_b, n_acc_b;
    logic [63:0]               r_pfx_hi, n_pfx_hi;
    logic [63:0]               r_pfx_lo, n_pfx_lo;
    logic [7:0]                r_small, n_small;
    logic [1:0]                r_flags, n_flags;

    logic [7:0]                b;
    logic [rap_pkg::LEN_W-1:0] len;
    logic                      is_last;
    logic [rap_pkg::OFF_W-1:0] optlen;
    logic [rap_pkg::LEN_W+1:0] remaining;
    logic                      rem_wrap;
    logic                      opt_done;
    logic                      have_a, have_b, have_end;
    rap_pkg::t_rec             rec_a, rec_b, rec_end, rec0, rec1;
    logic [1:0]                cnt;

    always_comb begin
        b = i_item.data_byte;
        if (i_item.packet_len > rap_pkg::LEN_W'(rap_pkg::MAX_MESSAGE_BYTES)) begin
            len = rap_pkg::LEN_W'(rap_pkg::MAX_MESSAGE_BYTES);
        end else if (i_item.packet_len == '0) begin
            len = rap_pkg::LEN_W'(1);
        end else begin
            len = i_item.packet_len;
        end
        is_last = ({1'b0, r_pos} + (rap_pkg::LEN_W+1)'(1)) >= {1'b0, len};

        optlen    = {b, 3'b000};
        remaining = {2'b00, len} + (rap_pkg::LEN_W+2)'(1) - {2'b00, r_pos};
        rem_wrap  = {1'b0, r_pos} > ({1'b0, len} + (rap_pkg::LEN_W+1)'(1));
        opt_done  = ({1'b0, r_off} + (rap_pkg::OFF_W+1)'(1)) >= {1'b0, r_opt_len};

        n_pos      = r_pos;
        n_phase    = r_phase;
        n_opt_type = r_opt_type;
        n_opt_len  = r_opt_len;
        n_off      = r_off;
        n_acc_a    = r_acc_a;
        n_acc_b    = r_acc_b;
        n_pfx_hi   = r_pfx_hi;
        n_pfx_lo   = r_pfx_lo;
        n_small    = r_small;
        n_flags    = r_flags;

        have_a   = 1'b0;
        have_b   = 1'b0;
        have_end = 1'b0;
        rec_a    = '0;
        rec_b    = '0;
        rec_end  = '0;
        rec_end.rec_kind = rap_pkg::REC_END;

        unique case (r_phase)
            rap_pkg::PH_TYPE: begin
                n_acc_a  = '0;
                n_acc_b  = '0;
                n_pfx_hi = '0;
                n_pfx_lo = '0;
                n_small  = '0;
                n_flags  = '0;
                if (b == rap_pkg::MSG_RA) begin
                    if (len < rap_pkg::LEN_W'(rap_pkg::HDR_BYTES)) begin
                        have_a         = 1'b1;
                        rec_a.rec_kind = rap_pkg::REC_TRUNC;
                        n_phase        = rap_pkg::PH_SKIP;
                    end else begin
                        n_phase = rap_pkg::PH_HDR;
                    end
                end else if (b == rap_pkg::MSG_RS) begin
                    n_phase = rap_pkg::PH_SKIP;
                end else begin
                    have_a         = 1'b1;
                    rec_a.rec_kind = rap_pkg::REC_FILTER;
                    n_phase        = rap_pkg::PH_SKIP;
                end
            end
            rap_pkg::PH_HDR: begin
                // hop limit, flags, reachable time, retransmit timer
                if (r_pos == 12'd4) begin
                    n_small = b;
                end else if (r_pos == 12'd5) begin
                    n_flags = {b[6], b[7]};
                end else if (r_pos >= 12'd8 && r_pos <= 12'd11) begin
                    n_acc_a = {r_acc_a[23:0], b};
                end else if (r_pos >= 12'd12 && r_pos <= 12'd15) begin
                    n_acc_b = {r_acc_b[23:0], b};
                end
                if (r_pos >= 12'd15) begin
                    have_a            = 1'b1;
                    rec_a.rec_kind    = rap_pkg::REC_HEADER;
                    rec_a.small_value = n_small;
                    rec_a.flag_a      = n_flags[0];
                    rec_a.flag_b      = n_flags[1];
                    rec_a.word_a      = n_acc_a;
                    rec_a.word_b      = n_acc_b;
                    n_phase           = rap_pkg::PH_OPT;
                    n_off             = '0;
                end else if (is_last) begin
                    have_a         = 1'b1;
                    rec_a.rec_kind = rap_pkg::REC_TRUNC;
                    n_phase        = rap_pkg::PH_SKIP;
                end
            end
            rap_pkg::PH_OPT: begin
                if (r_off == '0) begin
                    n_opt_type = b;
                    if (is_last) begin
                        have_a            = 1'b1;
                        rec_a.rec_kind    = rap_pkg::REC_TRAILING;
                        rec_a.option_type = b;
                        n_phase           = rap_pkg::PH_SKIP;
                    end else begin
                        n_off = rap_pkg::OFF_W'(1);
                    end
                end else if (r_off == rap_pkg::OFF_W'(1)) begin
                    if (optlen == '0 || (!rem_wrap &&
                            {3'b000, optlen} > remaining)) begin
                        have_a            = 1'b1;
                        rec_a.rec_kind    = (optlen == '0) ? rap_pkg::REC_ZERO_LEN
                                                           : rap_pkg::REC_OVERLONG;
                        rec_a.option_type = r_opt_type;
                        n_phase           = rap_pkg::PH_SKIP;
                    end else begin
                        n_opt_len = optlen;
                        n_off     = rap_pkg::OFF_W'(2);
                        n_acc_a   = '0;
                        n_acc_b   = '0;
                        n_pfx_hi  = '0;
                        n_pfx_lo  = '0;
                        n_small   = '0;
                        n_flags   = '0;
                    end
                end else begin
                    if (r_opt_type == rap_pkg::OPT_SRC_LLADDR) begin
                        have_a            = 1'b1;
                        rec_a.rec_kind    = rap_pkg::REC_LLADDR;
                        rec_a.small_value = b;
                        rec_a.option_type = r_opt_type;
                    end else if (r_opt_type == rap_pkg::OPT_PREFIX) begin
                        if (r_off == 11'd2) begin
                            n_small = b;
                        end else if (r_off == 11'd3) begin
                            n_flags = {b[6], b[7]};
                        end else if (r_off >= 11'd4 && r_off <= 11'd7) begin
                            n_acc_a = {r_acc_a[23:0], b};
                        end else if (r_off >= 11'd8 && r_off <= 11'd11) begin
                            n_acc_b = {r_acc_b[23:0], b};
                        end else if (r_off >= 11'd16 && r_off <= 11'd23) begin
                            n_pfx_hi = {r_pfx_hi[55:0], b};
                        end else if (r_off >= 11'd24 && r_off <= 11'd31) begin
                            n_pfx_lo = {r_pfx_lo[55:0], b};
                        end
                    end else if (r_opt_type == rap_pkg::OPT_MTU) begin
                        if (r_off >= 11'd4 && r_off <= 11'd7) begin
                            n_acc_a = {r_acc_a[23:0], b};
                        end
                    end

                    if (opt_done) begin
                        if (r_opt_type == rap_pkg::OPT_MTU) begin
                            have_a            = 1'b1;
                            rec_a.rec_kind    = rap_pkg::REC_MTU;
                            rec_a.word_a      = n_acc_a;
                            rec_a.option_type = r_opt_type;
                        end else if (r_opt_type == rap_pkg::OPT_PREFIX) begin
                            have_a                   = 1'b1;
                            rec_a.rec_kind           = rap_pkg::REC_PREFIX;
                            rec_a.small_value        = n_small;
                            rec_a.flag_a             = n_flags[0];
                            rec_a.flag_b             = n_flags[1];
                            rec_a.word_a             = n_acc_a;
                            rec_a.word_b             = n_acc_b;
                            rec_a.prefix_high        = n_pfx_hi;
                            rec_a.prefix_low         = n_pfx_lo;
                            rec_a.option_type        = r_opt_type;
                            rec_a.valid_infinite     = (n_acc_a == '1);
                            rec_a.preferred_infinite = (n_acc_b == '1);
                        end else if (r_opt_type == rap_pkg::OPT_TGT_LLADDR ||
                                     r_opt_type == rap_pkg::OPT_REDIR_HDR) begin
                            have_a            = 1'b1;
                            rec_a.rec_kind    = rap_pkg::REC_INVALID;
                            rec_a.option_type = r_opt_type;
                        end else if (r_opt_type != rap_pkg::OPT_SRC_LLADDR) begin
                            have_a            = 1'b1;
                            rec_a.rec_kind    = rap_pkg::REC_UNKNOWN;
                            rec_a.option_type = r_opt_type;
                        end
                        n_off = '0;
                    end else if (is_last) begin
                        have_b            = 1'b1;
                        rec_b.rec_kind    = rap_pkg::REC_OVERLONG;
                        rec_b.option_type = r_opt_type;
                        n_phase           = rap_pkg::PH_SKIP;
                    end else begin
                        n_off = r_off + rap_pkg::OFF_W'(1);
                    end
                end
            end
            rap_pkg::PH_SKIP: begin
            end
            default: begin
            end
        endcase

        // Clean end of an advertisement
        have_end = is_last && (n_phase == rap_pkg::PH_OPT) && (n_off == '0);

        if (is_last) begin
            n_pos   = '0;
            n_phase = rap_pkg::PH_TYPE;
            n_off   = '0;
        end else begin
            n_pos = r_pos + rap_pkg::LEN_W'(1);
        end

        // Pack the records in order into the two push slots
        rec0 = '0;
        rec1 = '0;
        cnt  = 2'd0;
        if (have_a) begin
            rec0 = rec_a;
            cnt  = 2'd1;
        end
        if (have_b) begin
            if (cnt == 2'd0) begin
                rec0 = rec_b;
            end else begin
                rec1 = rec_b;
            end
            cnt = cnt + 2'd1;
        end
        if (have_end) begin
            if (cnt == 2'd0) begin
                rec0 = rec_end;
            end else begin
                rec1 = rec_end;
            end
            cnt = cnt + 2'd1;
        end
        if (cnt == 2'd1) begin
            rec0.last = 1'b1;
        end else if (cnt == 2'd2) begin
            rec1.last = 1'b1;
        end

        o_push.count = i_go ? cnt : 2'd0;
        o_push.rec0  = rec0;
        o_push.rec1  = rec1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= rap_pkg::PH_TYPE;
            r_opt_type <= '0;
            r_opt_len  <= '0;
            r_off      <= '0;
            r_acc_a    <= '0;
            r_acc_b    <= '0;
            r_pfx_hi   <= '0;
            r_pfx_lo   <= '0;
            r_small    <= '0;
            r_flags    <= '0;
        end else if (i_go) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_opt_type <= n_opt_type;
            r_opt_len  <= n_opt_len;
            r_off      <= n_off;
            r_acc_a    <= n_acc_a;
            r_acc_b    <= n_acc_b;
            r_pfx_hi   <= n_pfx_hi;
            r_pfx_lo   <= n_pfx_lo;
            r_small    <= n_small;
            r_flags    <= n_flags;
        end
    end

endmodule

// File: sv/rap_outq.sv
// ----------------------------------------------------------------------------
// Router advertisement parser output queue
// Small register queue: up to two records in a cycle, one out unless i_stall.
// ----------------------------------------------------------------------------
module rap_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rap_pkg::t_push i_push,
    input  logic           i_stall,
    output logic           o_valid,
    output rap_pkg::t_rec  o_data,
    output logic           o_room
);

    rap_pkg::t_rec              r_mem [rap_pkg::OQ_DEPTH];
    logic [rap_pkg::OQ_AW-1:0]  r_wr, n_wr;
    logic [rap_pkg::OQ_AW-1:0]  r_rd, n_rd;
    logic [rap_pkg::OQ_AW:0]    r_cnt, n_cnt;
    logic [rap_pkg::OQ_AW-1:0]  wr_next;
    logic                       pop;

    always_comb begin
        pop     = (r_cnt != '0) && !i_stall;
        wr_next = r_wr + rap_pkg::OQ_AW'(1);
        n_wr    = r_wr + rap_pkg::OQ_AW'(i_push.count);
        n_rd    = pop ? (r_rd + rap_pkg::OQ_AW'(1)) : r_rd;
        n_cnt   = r_cnt + (rap_pkg::OQ_AW+1)'(i_push.count)
                        - (rap_pkg::OQ_AW+1)'(pop);
        o_valid = (r_cnt != '0);
        o_data  = r_mem[r_rd];
        o_room  = r_cnt <= (rap_pkg::OQ_AW+1)'(rap_pkg::OQ_DEPTH - 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: sv/router_advert_option_parser_top.sv
// ----------------------------------------------------------------------------
// Router advertisement option parser
// Byte-serial ICMPv6 router advertisement parser producing option records.
// ----------------------------------------------------------------------------
// Path: a request accepted into the input register is parsed by the core
// once the queue has room; its records are written into the output queue
// and are visible on o_valid/o_data from then on. Throughput: one byte per
// cycle while o_stall is low; each byte is parsed in a single pass by the
// core, and up to two records per byte drain one per cycle while i_stall
// is low from a four-entry queue; input stalls while over two records wait.
// Reset: i_rst_n low at a clock edge empties the queue and input register
// and returns the parser to waiting for a message type byte.
// ----------------------------------------------------------------------------
module router_advert_option_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Byte request channel
    input  logic          i_valid,
    output logic          o_stall,
    input  rap_pkg::t_in  i_data,
    // Record channel
    output logic          o_valid,
    input  logic          i_stall,
    output rap_pkg::t_rec o_data
);

    // Input register: hold one request until the core can parse it
    logic           r_in_valid, n_in_valid;
    rap_pkg::t_in   r_in;
    logic           room;
    logic           go;
    logic           take;
    rap_pkg::t_push push;

    always_comb begin
        // Parse the held request only when the queue can absorb two records
        go         = r_in_valid && room;
        o_stall    = r_in_valid && !room;
        take       = i_valid && !o_stall;
        n_in_valid = take ? 1'b1 : (go ? 1'b0 : r_in_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload needs no reset; load it with each accepted request
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_data;
        end
    end

    // Parse state and record generation
    rap_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .o_push  (push)
    );

    // Record queue toward the consumer
    rap_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_room  (room)
    );

endmodule

// File: bench/router_advert_option_parser_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Router advertisement option parser testbench
// Feeds ICMPv6 messages byte by byte through the request channel and checks
// every record against pinned rows or an in-bench model: a directed walk over
// edge cases, then random messages: four idle mixes and a long receiver hold.
// ----------------------------------------------------------------------------
module router_advert_option_parser_top_test;
    import rap_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_BYTES   = 725;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 20;
    // Record count column of the directed rows: left to the parser model
    localparam int BY_MODEL       = -1;

    typedef struct {
        int   count;
        t_rec rec;
    } t_fixed_result;

    typedef struct {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] len;
        int               count;
        logic [3:0]       kind;
        logic [7:0]       opt;
    } t_directed_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_rec  o_data;

    router_advert_option_parser_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser model state
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] msg_pos;
    t_phase           parse_ph;
    logic [7:0]       opt_type_r;
    logic [OFF_W-1:0] opt_len_r;
    logic [OFF_W-1:0] opt_off;
    logic [31:0]      acc_word_a;
    logic [31:0]      acc_word_b;
    logic [63:0]      acc_pfx_hi;
    logic [63:0]      acc_pfx_lo;
    logic [7:0]       acc_small;
    logic [1:0]       acc_flags;

    // Records caused by the byte just parsed
    t_rec byte_recs [2];
    int   byte_rec_cnt;

    // Records still owed by the block, oldest first
    t_rec          pending_recs [$];
    // One entry per request handed to the channel, popped on acceptance
    t_fixed_result pinned_q [$];

    // Bytes of the message under construction and their length fields
    logic [7:0]       msg_bytes [$];
    logic [LEN_W-1:0] msg_lens [$];

    int        fails        = 0;
    int        bytes_sent   = 0;
    int        bytes_taken  = 0;
    int        recs_checked = 0;
    int        msgs_sent    = 0;
    int        idle_pct     = 0;
    int        stall_pct    = 0;
    int        quiet_cycles = 0;
    bit        hold_rx      = 1'b0;
    bit [15:0] kinds_seen   = '0;

    // Directed walk. The kind and option columns are read only where the row
    // pins exactly one record; a count of BY_MODEL hands the row to the model.
    t_directed_row directed_rows [25] = '{
        // solicitation that ends at once: nothing comes out
        '{MSG_RS,   12'd1,    0,        REC_HEADER,   8'd0},
        // zero length counts as one byte; unknown type is filtered
        '{8'h00,    12'd0,    1,        REC_FILTER,   8'd0},
        // length above the cap, then shrink it so the message ends next byte
        '{8'hff,    12'd4095, 1,        REC_FILTER,   8'd0},
        '{8'haa,    12'd2,    0,        REC_HEADER,   8'd0},
        // advertisement too short for its header
        '{MSG_RA,   12'd15,   1,        REC_TRUNC,    8'd0},
        '{8'h55,    12'd2,    0,        REC_HEADER,   8'd0},
        // header cut short by a length change on its second byte
        '{MSG_RA,   12'd16,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd2,    1,        REC_TRUNC,    8'd0},
        // full header with extreme fields, then one lone option byte
        '{MSG_RA,   12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h12,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h34,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hc0,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'hff,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd17,   0,        REC_HEADER,   8'd0},
        '{8'h00,    12'd17,   BY_MODEL, REC_HEADER,   8'd0},
        '{OPT_MTU,  12'd17,   1,        REC_TRAILING, OPT_MTU}
    };

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_accums();
        acc_word_a = '0;
        acc_word_b = '0;
        acc_pfx_hi = '0;
        acc_pfx_lo = '0;
        acc_small  = '0;
        acc_flags  = '0;
    endfunction

    function automatic t_rec bare_rec(logic [3:0] kind, logic [7:0] opt);
        t_rec r;
        r = '0;
        r.rec_kind    = kind;
        r.option_type = opt;
        return r;
    endfunction

    // Header and prefix records share the hop/flag/lifetime layout
    function automatic t_rec accum_rec(logic [3:0] kind, logic [7:0] opt);
        t_rec r;
        r = bare_rec(kind, opt);
        r.small_value = acc_small;
        r.flag_a      = acc_flags[0];
        r.flag_b      = acc_flags[1];
        r.word_a      = acc_word_a;
        r.word_b      = acc_word_b;
        return r;
    endfunction

    function automatic void emit(t_rec r);
        byte_recs[byte_rec_cnt] = r;
        byte_rec_cnt++;
    endfunction

    // Advance the model by one request byte; records land in byte_recs
    function automatic void parse_byte(t_in req);
        int          len;
        int          pos;
        int          o;
        logic [31:0] optlen;
        logic [31:0] room;
        bit          at_end;
        bit          opt_done;
        logic [7:0]  b;
        logic [7:0]  t;
        t_rec        r;
        b   = req.data_byte;
        len = int'(req.packet_len);
        pos = int'(msg_pos);
        if (len > MAX_MESSAGE_BYTES) len = MAX_MESSAGE_BYTES;
        if (len == 0) len = 1;
        at_end = (pos + 1 >= len);
        byte_rec_cnt = 0;
        case (parse_ph)
            PH_TYPE: begin
                clear_accums();
                if (b == MSG_RA) begin
                    if (len < HDR_BYTES) begin
                        emit(bare_rec(REC_TRUNC, 8'd0));
                        parse_ph = PH_SKIP;
                    end else begin
                        parse_ph = PH_HDR;
                    end
                end else begin
                    if (b != MSG_RS) emit(bare_rec(REC_FILTER, 8'd0));
                    parse_ph = PH_SKIP;
                end
            end
            PH_HDR: begin
                if (pos == 4) acc_small = b;
                else if (pos == 5) acc_flags = {b[6], b[7]};
                else if (pos >= 8 && pos <= 11) acc_word_a = {acc_word_a[23:0], b};
                else if (pos >= 12 && pos <= 15) acc_word_b = {acc_word_b[23:0], b};
                if (pos >= HDR_BYTES - 1) begin
                    emit(accum_rec(REC_HEADER, 8'd0));
                    parse_ph = PH_OPT;
                    opt_off  = '0;
                end else if (at_end) begin
                    emit(bare_rec(REC_TRUNC, 8'd0));
                    parse_ph = PH_SKIP;
                end
            end
            PH_OPT: begin
                o = int'(opt_off);
                if (o == 0) begin
                    opt_type_r = b;
                    if (at_end) begin
                        emit(bare_rec(REC_TRAILING, b));
                        parse_ph = PH_SKIP;
                    end else begin
                        opt_off = OFF_W'(1);
                    end
                end else if (o == 1) begin
                    // room wraps as an unsigned word when the length shrank
                    optlen = 32'(b) << 3;
                    room   = 32'(len - pos + 1);
                    if (optlen == 0 || optlen > room) begin
                        emit(bare_rec((optlen == 0) ? REC_ZERO_LEN : REC_OVERLONG,
                                      opt_type_r));
                        parse_ph = PH_SKIP;
                    end else begin
                        opt_len_r = OFF_W'(optlen);
                        opt_off   = OFF_W'(2);
                        clear_accums();
                    end
                end else begin
                    t        = opt_type_r;
                    opt_done = (o + 1 >= int'(opt_len_r));
                    if (t == OPT_SRC_LLADDR) begin
                        r = bare_rec(REC_LLADDR, t);
                        r.small_value = b;
                        emit(r);
                    end else if (t == OPT_PREFIX) begin
                        if (o == 2) acc_small = b;
                        else if (o == 3) acc_flags = {b[6], b[7]};
                        else if (o >= 4 && o <= 7) acc_word_a = {acc_word_a[23:0], b};
                        else if (o >= 8 && o <= 11) acc_word_b = {acc_word_b[23:0], b};
                        else if (o >= 16 && o <= 23) acc_pfx_hi = {acc_pfx_hi[55:0], b};
                        else if (o >= 24 && o <= 31) acc_pfx_lo = {acc_pfx_lo[55:0], b};
                    end else if (t == OPT_MTU) begin
                        if (o >= 4 && o <= 7) acc_word_a = {acc_word_a[23:0], b};
                    end
                    if (opt_done) begin
                        if (t == OPT_MTU) begin
                            r = bare_rec(REC_MTU, t);
                            r.word_a = acc_word_a;
                            emit(r);
                        end else if (t == OPT_PREFIX) begin
                            r = accum_rec(REC_PREFIX, t);
                            r.prefix_high        = acc_pfx_hi;
                            r.prefix_low         = acc_pfx_lo;
                            r.valid_infinite     = (acc_word_a == '1);
                            r.preferred_infinite = (acc_word_b == '1);
                            emit(r);
                        end else if (t == OPT_TGT_LLADDR || t == OPT_REDIR_HDR) begin
                            emit(bare_rec(REC_INVALID, t));
                        end else if (t != OPT_SRC_LLADDR) begin
                            emit(bare_rec(REC_UNKNOWN, t));
                        end
                        opt_off = '0;
                    end else if (at_end) begin
                        emit(bare_rec(REC_OVERLONG, t));
                        parse_ph = PH_SKIP;
                    end else begin
                        opt_off = OFF_W'(o + 1);
                    end
                end
            end
            default: ;
        endcase
        if (at_end && parse_ph == PH_OPT && opt_off == 0)
            emit(bare_rec(REC_END, 8'd0));
        if (byte_rec_cnt > 0) byte_recs[byte_rec_cnt - 1].last = 1'b1;
        if (at_end) begin
            msg_pos  = '0;
            parse_ph = PH_TYPE;
            opt_off  = '0;
        end else begin
            msg_pos = msg_pos + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("record %0d %s: expected %h, actual %h", recs_checked, name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_record(t_rec want, t_rec got);
        check_field("rec_kind",           64'(want.rec_kind),           64'(got.rec_kind));
        check_field("small_value",        64'(want.small_value),        64'(got.small_value));
        check_field("flag_a",             64'(want.flag_a),             64'(got.flag_a));
        check_field("flag_b",             64'(want.flag_b),             64'(got.flag_b));
        check_field("word_a",             64'(want.word_a),             64'(got.word_a));
        check_field("word_b",             64'(want.word_b),             64'(got.word_b));
        check_field("prefix_high",        want.prefix_high,             got.prefix_high);
        check_field("prefix_low",         want.prefix_low,              got.prefix_low);
        check_field("option_type",        64'(want.option_type),        64'(got.option_type));
        check_field("valid_infinite",     64'(want.valid_infinite),     64'(got.valid_infinite));
        check_field("preferred_infinite", 64'(want.preferred_infinite),
                    64'(got.preferred_infinite));
        check_field("last",               64'(want.last),               64'(got.last));
    endfunction

    // Sample both channels at the edge with pre-edge values. Predict before
    // checking so a same-edge request and record never race.
    always @(posedge i_clk) begin : monitor
        t_fixed_result fx;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data);
                fx = pinned_q.pop_front();
                if (fx.count == BY_MODEL) begin
                    for (int k = 0; k < byte_rec_cnt; k++) pending_recs.push_back(byte_recs[k]);
                end else if (fx.count == 1) begin
                    pending_recs.push_back(fx.rec);
                end
                bytes_taken++;
            end
            if (o_valid && !i_stall) begin
                if (pending_recs.size() == 0) begin
                    $error("record %0d arrived with none outstanding (kind %0d)",
                           recs_checked, o_data.rec_kind);
                    fails++;
                end else begin
                    check_record(pending_recs.pop_front(), o_data);
                end
                kinds_seen[o_data.rec_kind] = 1'b1;
                recs_checked++;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold when asked
    // ------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                // hold off long enough to fill the block and back up requests
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one request and hold it until accepted. Valid stays high when
    // no gap is drawn, so back-to-back requests see one assignment per edge.
    task automatic send_byte(t_in req, t_fixed_result fx);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        pinned_q.push_back(fx);
        bytes_sent++;
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait until every owed record has come out
    task automatic drain_records();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pinned_q.size() != 0 || pending_recs.size() != 0);
    endtask

    function automatic void put_option(logic [7:0] otype, int units);
        int base;
        base = msg_bytes.size();
        msg_bytes.push_back(otype);
        msg_bytes.push_back(8'(units));
        repeat (units * 8 - 2) msg_bytes.push_back(8'($urandom));
        // Force infinite lifetimes now and then, where the option holds them
        if (otype == OPT_PREFIX && units * 8 > 7 && $urandom_range(2) == 0)
            for (int k = 4; k < 8; k++) msg_bytes[base + k] = 8'hff;
        if (otype == OPT_PREFIX && units * 8 > 11 && $urandom_range(2) == 0)
            for (int k = 8; k < 12; k++) msg_bytes[base + k] = 8'hff;
    endfunction

    function automatic void random_option();
        case ($urandom_range(7))
            0, 1: put_option(OPT_SRC_LLADDR, $urandom_range(2, 1));
            // mostly full prefix options, sometimes short or padded
            2, 3: put_option(OPT_PREFIX, ($urandom_range(3) == 0) ? $urandom_range(5, 1) : 4);
            4: put_option(OPT_MTU, 1);
            5: put_option(($urandom_range(1) == 0) ? OPT_TGT_LLADDR : OPT_REDIR_HDR, 1);
            default: put_option(8'($urandom), $urandom_range(2, 1));
        endcase
    endfunction

    // Build one message and send it. Most are clean advertisements; the
    // rest are broken ones, other message types, and unstable lengths.
    task automatic send_random_message();
        int            pick;
        int            cut;
        t_in           req;
        t_fixed_result fx;
        fx.count = BY_MODEL;
        fx.rec   = '0;
        msg_bytes.delete();
        msg_lens.delete();
        pick = $urandom_range(99);
        if (pick < 80) begin
            msg_bytes.push_back(MSG_RA);
            repeat (HDR_BYTES - 1) msg_bytes.push_back(8'($urandom));
            repeat ($urandom_range(4)) random_option();
        end else begin
            msg_bytes.push_back(($urandom_range(1) == 0) ? MSG_RS : 8'($urandom));
            repeat ($urandom_range(11)) msg_bytes.push_back(8'($urandom));
        end
        if (pick >= 55 && pick < 75) begin
            case ($urandom_range(3))
                // lone byte where an option would start
                0: msg_bytes.push_back(8'($urandom));
                // option claiming zero length
                1: begin
                    msg_bytes.push_back(8'($urandom));
                    msg_bytes.push_back(8'd0);
                    repeat ($urandom_range(6)) msg_bytes.push_back(8'($urandom));
                end
                // option longer than what is left of the message
                2: begin
                    msg_bytes.push_back(8'($urandom));
                    msg_bytes.push_back(8'($urandom_range(255, 2)));
                    repeat ($urandom_range(5)) msg_bytes.push_back(8'($urandom));
                end
                // message ends early: inside the header or inside an option
                default: begin
                    cut = $urandom_range(msg_bytes.size() - 1, 1);
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                end
            endcase
        end
        foreach (msg_bytes[k]) msg_lens.push_back(LEN_W'(msg_bytes.size()));
        if (pick >= 75 && pick < 80) begin
            // scramble lengths mid-message; end on a length of 0 or 1 to resync
            foreach (msg_lens[k]) if ($urandom_range(3) == 0) msg_lens[k] = LEN_W'($urandom);
            msg_lens[msg_lens.size() - 1] = LEN_W'($urandom_range(1));
        end
        foreach (msg_bytes[k]) begin
            req.data_byte  = msg_bytes[k];
            req.packet_len = msg_lens[k];
            send_byte(req, fx);
        end
        msgs_sent++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in           req;
        t_fixed_result fx;
        int            goal;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        msg_pos  = '0;
        parse_ph = PH_TYPE;
        opt_type_r = '0;
        opt_len_r  = '0;
        opt_off    = '0;
        clear_accums();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows with both sides running flat out
        foreach (directed_rows[k]) begin
            req.data_byte  = directed_rows[k].data_byte;
            req.packet_len = directed_rows[k].len;
            fx.count = directed_rows[k].count;
            fx.rec   = bare_rec(directed_rows[k].kind, directed_rows[k].opt);
            fx.rec.last = 1'b1;
            send_byte(req, fx);
        end
        drain_records();

        // Random messages under each idle mix; pause the sender at the end
        // of every mix until all owed records have drained
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    // long receiver hold while the sender keeps pushing
                    hold_rx   = 1'b1;
                end
                1: begin
                    idle_pct  = 61;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 61;
                end
                default: begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            goal = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < goal) send_random_message();
            drain_records();
        end

        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_recs.size() != 0) begin
            $error("%0d records never arrived", pending_recs.size());
            fails++;
        end

        $display("Parsed %0d request bytes (%0d random messages) and checked %0d records",
                 bytes_taken, msgs_sent, recs_checked);
        $display("Saw %0d of 12 record kinds across four idle mixes and one long hold",
                 $countones(kinds_seen));
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
